// File: hdl/imuatt_pkg.sv
package imuatt_pkg;

  // CORDIC iteration count and the length of its arctangent table.
  localparam int unsigned CORDIC_ITER_DEF = 16;
  localparam int unsigned ATAN_LEN        = 24;

  // Bit-serial square root step count and the phase count of the reciprocal divider.
  localparam int unsigned SQRT_STEPS = 24;
  localparam int unsigned DIV_STEPS  = 4;

  // Width of the sequencer's step counter and of the iteration field.
  localparam int unsigned ITER_W = 6;

  // Datapath widths.
  localparam int unsigned ACC_W  = 40;
  localparam int unsigned COR_W  = 44;
  localparam int unsigned ZW     = 32;
  localparam int unsigned SQ_W   = 48;
  localparam int unsigned DVS_W  = 17;

  // Angle limit in hundredths of a degree.
  localparam logic signed [15:0] ANGLE_LIMIT = 16'sd18000;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_FAIL,
    OP_SQ_A,
    OP_SQ_B,
    OP_SQRT,
    OP_COR_INIT,
    OP_COR_STEP,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_DIV_DONE,
    OP_DIRECT,
    OP_BL_MUL,
    OP_BL_ADD,
    OP_BL_SCALE,
    OP_BL_ACC,
    OP_YAW_MUL,
    OP_FINISH
  } op_e;

  // Where a divider result goes, which also picks divisor and dividend.
  typedef enum logic [2:0] {
    T_ACC_ROLL,
    T_ACC_PITCH,
    T_ROLL,
    T_PITCH,
    T_YAW
  } tgt_e;

  typedef struct packed {
    op_e               op;
    tgt_e              tgt;
    logic              axis;   // 0 roll, 1 pitch
    logic              ok;
    logic [ITER_W-1:0] iter;
  } cmd_t;

  typedef struct packed {
    logic started;
    logic sample_ok;
    logic direct;    // no filtered update possible: load accelerometer angles
  } stat_t;

  // Arctangent of 2^-i in micro-degrees.
  function automatic logic [26:0] atan_udeg(input logic [4:0] i);
    logic [26:0] r;
    case (i)
      5'd0:    r = 27'd45000000;
      5'd1:    r = 27'd26565051;
      5'd2:    r = 27'd14036243;
      5'd3:    r = 27'd7125016;
      5'd4:    r = 27'd3576334;
      5'd5:    r = 27'd1789911;
      5'd6:    r = 27'd895174;
      5'd7:    r = 27'd447614;
      5'd8:    r = 27'd223811;
      5'd9:    r = 27'd111906;
      5'd10:   r = 27'd55953;
      5'd11:   r = 27'd27976;
      5'd12:   r = 27'd13988;
      5'd13:   r = 27'd6994;
      5'd14:   r = 27'd3497;
      5'd15:   r = 27'd1749;
      5'd16:   r = 27'd874;
      5'd17:   r = 27'd437;
      5'd18:   r = 27'd219;
      5'd19:   r = 27'd109;
      5'd20:   r = 27'd55;
      5'd21:   r = 27'd27;
      5'd22:   r = 27'd14;
      5'd23:   r = 27'd7;
      default: r = 27'd0;
    endcase
    return r;
  endfunction

endpackage

// File: hdl/imuatt_in_if.sv
interface imuatt_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] accel_x;
  logic signed [15:0] accel_y;
  logic signed [15:0] accel_z;
  logic signed [15:0] gyro_x;
  logic signed [15:0] gyro_y;
  logic signed [15:0] gyro_z;
  logic               sample_ok;
  logic [31:0]        now_ms;

  modport source (
    output valid, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z, sample_ok, now_ms,
    input  ready
  );
  modport sink (
    input  valid, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z, sample_ok, now_ms,
    output ready
  );
endinterface

// File: hdl/imuatt_out_if.sv
interface imuatt_out_if;
  logic               valid;
  logic               ready;
  logic               ok;
  logic signed [15:0] roll_angle;
  logic signed [15:0] pitch_angle;
  logic signed [15:0] yaw_rate;
  logic               attitude_valid;

  modport source (
    output valid, ok, roll_angle, pitch_angle, yaw_rate, attitude_valid,
    input  ready
  );
  modport sink (
    input  valid, ok, roll_angle, pitch_angle, yaw_rate, attitude_valid,
    output ready
  );
endinterface

// File: hdl/imuatt_cfg_if.sv
interface imuatt_cfg_if;
  logic valid;
  logic ready;
  logic data;

  modport source (
    output valid, data,
    input  ready
  );
  modport sink (
    input  valid, data,
    output ready
  );
endinterface

// File: hdl/imu_complementary_attitude.sv
// Roll/pitch attitude estimator for raw six-axis IMU samples. Each input beat carries three
// accelerometer and three gyro axes, a read-ok flag and a millisecond timestamp; each beat
// yields exactly one result beat with the ok flag, filtered roll and pitch in hundredths of a
// degree (saturated to +/-18000), the gyro z rate in hundredths of a degree per second, and the
// attitude-valid flag. Accelerometer angles come from a vectoring CORDIC (atan2) fed by a
// bit-serial integer square root; when a previous estimate exists and elapsed time is positive
// (clamped to 65535 ms), a 0.98/0.02 complementary filter blends the gyro-integrated angles with
// them, otherwise they are loaded directly. The single configuration register, sensor_started,
// gates all updates; writing 1 restarts the estimator. Write it only while the block is idle.
// Items are processed one at a time. Each update runs the 24-step square root and the
// two CORDIC passes; the shared rounding divider, a reciprocal multiplication with one
// correction, runs five times per full update (two angle roundings, two filter divisions,
// yaw). A result waiting in the output register does not block accepting the next sample.
module imu_complementary_attitude #(
  parameter int unsigned CORDIC_ITERATIONS = imuatt_pkg::CORDIC_ITER_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  imuatt_in_if.sink    sample_i,
  imuatt_out_if.source result_o,
  imuatt_cfg_if.sink   cfg_i
);
  import imuatt_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // The register write is always accepted: ready is tied high.
  assign cfg_i.ready = 1'b1;

  // The sequencer walks each good beat through square root, CORDIC, filter and divider steps.
  imuatt_ctrl #(
    .CORDIC_ITERATIONS(CORDIC_ITERATIONS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (sample_i.valid),
    .in_ready_o  (sample_i.ready),
    .out_valid_o (result_o.valid),
    .out_ready_i (result_o.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // The datapath holds the estimator state, the arithmetic units and the output register.
  imuatt_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .cfg_we_i         (cfg_i.valid),
    .cfg_data_i       (cfg_i.data),
    .accel_x_i        (sample_i.accel_x),
    .accel_y_i        (sample_i.accel_y),
    .accel_z_i        (sample_i.accel_z),
    .gyro_x_i         (sample_i.gyro_x),
    .gyro_y_i         (sample_i.gyro_y),
    .gyro_z_i         (sample_i.gyro_z),
    .sample_ok_i      (sample_i.sample_ok),
    .now_ms_i         (sample_i.now_ms),
    .ok_o             (result_o.ok),
    .roll_angle_o     (result_o.roll_angle),
    .pitch_angle_o    (result_o.pitch_angle),
    .yaw_rate_o       (result_o.yaw_rate),
    .attitude_valid_o (result_o.attitude_valid)
  );

endmodule

// File: hdl/imuatt_dp.sv
module imuatt_dp (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  imuatt_pkg::cmd_t   cmd_i,
  output imuatt_pkg::stat_t  stat_o,
  input  logic               cfg_we_i,
  input  logic               cfg_data_i,
  input  logic signed [15:0] accel_x_i,
  input  logic signed [15:0] accel_y_i,
  input  logic signed [15:0] accel_z_i,
  input  logic signed [15:0] gyro_x_i,
  input  logic signed [15:0] gyro_y_i,
  input  logic signed [15:0] gyro_z_i,
  input  logic               sample_ok_i,
  input  logic [31:0]        now_ms_i,
  output logic               ok_o,
  output logic signed [15:0] roll_angle_o,
  output logic signed [15:0] pitch_angle_o,
  output logic signed [15:0] yaw_rate_o,
  output logic               attitude_valid_o
);
  import imuatt_pkg::*;

  localparam logic signed [11:0] K_OLD   = 12'sd1310;
  localparam logic signed [7:0]  K_BLEND = 8'sd98;
  localparam logic signed [12:0] K_ACC   = 13'sd2620;
  localparam logic signed [7:0]  K_YAW   = 8'sd100;
  localparam logic signed [ZW-1:0] Z_HALF_TURN = 32'sd180000000;

  // Reciprocal division: each dividend magnitude stays below 2^shift, so the
  // floor reciprocal leaves the estimate at most one short of the quotient.
  localparam int unsigned SH_ANG = 29;
  localparam int unsigned SH_FLT = 38;
  localparam int unsigned SH_YAW = 22;
  localparam logic [21:0] RCP_ANG = 22'((64'd1 << SH_ANG) / 64'd10000);
  localparam logic [21:0] RCP_FLT = 22'((64'd1 << SH_FLT) / 64'd131000);
  localparam logic [21:0] RCP_YAW = 22'((64'd1 << SH_YAW) / 64'd131);

  // Divider phases.
  localparam logic [1:0] PH_LO  = 2'd0;
  localparam logic [1:0] PH_HI  = 2'd1;
  localparam logic [1:0] PH_EST = 2'd2;
  localparam logic [1:0] PH_FIX = 2'd3;

  function automatic logic signed [15:0] sat_angle(input logic signed [ACC_W:0] v);
    logic signed [15:0] r;
    if (v > (ACC_W+1)'(ANGLE_LIMIT)) begin
      r = ANGLE_LIMIT;
    end else if (v < -(ACC_W+1)'(ANGLE_LIMIT)) begin
      r = -ANGLE_LIMIT;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  // Captured sample.
  logic signed [15:0] ax_q, ay_q, az_q, gx_q, gy_q, gz_q;
  logic [31:0]        now_q;
  logic               sok_q;

  // Estimator state.
  logic               started_q, valid_q;
  logic [31:0]        last_q;
  logic [15:0]        dt_q;
  logic signed [15:0] roll_q, pitch_q, yaw_q, acc_roll_q, acc_pitch_q;

  // Square root.
  logic [31:0]     sq_p_q;
  logic [SQ_W-1:0] sq_v_q, sq_res_q, sq_bit_q;

  // CORDIC.
  logic signed [COR_W-1:0] cx_q, cy_q;
  logic signed [ZW-1:0]    cz_q;
  logic                    czero_q;

  // Multiply-accumulate and divider.
  logic signed [ACC_W-1:0] acc_q;
  logic [ACC_W-1:0]        dvd_q;
  logic [DVS_W-1:0]        dvs_q;
  logic                    dneg_q;
  logic [63:0]             prod_q;
  logic [23:0]             quo_q;

  // Output register.
  logic               o_ok_q, o_valid_q;
  logic signed [15:0] o_roll_q, o_pitch_q, o_yaw_q;

  // Combinational helpers.
  logic [SQ_W-1:0]         sq_trial;
  logic [31:0]             az_sq;
  logic [31:0]             diff;
  logic signed [16:0]      ax_neg;
  logic signed [26:0]      x0, y0;
  logic signed [COR_W-1:0] xs, ys;
  logic signed [ZW-1:0]    atan_s;
  logic signed [ACC_W-1:0] div_n, div_mag;
  logic [DVS_W-1:0]        div_d;
  logic [21:0]             rcp;
  logic [23:0]             q_est;
  logic [40:0]             p_lo, p_hi, q_back;
  logic [ACC_W-1:0]        rem_chk;
  logic signed [ACC_W:0]   quot;
  logic signed [15:0]      old_a, g_a, ang_a;
  logic signed [32:0]      p_gdt;
  logic signed [27:0]      p_old;
  logic signed [47:0]      p_scale;
  logic signed [28:0]      p_acc;
  logic signed [23:0]      p_yaw;

  always_comb begin
    sq_trial = sq_res_q + sq_bit_q;
    az_sq    = 32'(az_q * az_q);
    diff     = now_q - last_q;
    ax_neg   = -17'(ax_q);
    if (cmd_i.axis) begin
      y0 = {{2{ax_neg[16]}}, ax_neg, 8'b0};
      x0 = {2'b00, sq_res_q[24:0]};
    end else begin
      y0 = {{3{ay_q[15]}}, ay_q, 8'b0};
      x0 = {{3{az_q[15]}}, az_q, 8'b0};
    end
    xs     = cx_q >>> cmd_i.iter[4:0];
    ys     = cy_q >>> cmd_i.iter[4:0];
    atan_s = ZW'(signed'({1'b0, atan_udeg(cmd_i.iter[4:0])}));

    case (cmd_i.tgt)
      T_ACC_ROLL, T_ACC_PITCH: begin
        div_n = czero_q ? '0 : ACC_W'(cz_q);
        div_d = DVS_W'(10000);
        rcp   = RCP_ANG;
        q_est = 24'(prod_q >> SH_ANG);
      end
      T_ROLL, T_PITCH: begin
        div_n = acc_q;
        div_d = DVS_W'(131000);
        rcp   = RCP_FLT;
        q_est = 24'(prod_q >> SH_FLT);
      end
      default: begin
        div_n = acc_q;
        div_d = DVS_W'(131);
        rcp   = RCP_YAW;
        q_est = 24'(prod_q >> SH_YAW);
      end
    endcase
    div_mag = (div_n < 0) ? -div_n : div_n;
    p_lo    = dvd_q[18:0] * rcp;
    p_hi    = dvd_q[37:19] * rcp;
    q_back  = quo_q * dvs_q;
    rem_chk = dvd_q - ACC_W'(q_back);
    quot    = dneg_q ? -signed'((ACC_W+1)'(quo_q)) : signed'((ACC_W+1)'(quo_q));

    old_a   = cmd_i.axis ? pitch_q : roll_q;
    g_a     = cmd_i.axis ? gy_q : gx_q;
    ang_a   = cmd_i.axis ? acc_pitch_q : acc_roll_q;
    p_gdt   = g_a * signed'({1'b0, dt_q});
    p_old   = old_a * K_OLD;
    p_scale = acc_q * K_BLEND;
    p_acc   = ang_a * K_ACC;
    p_yaw   = gz_q * K_YAW;
  end

  assign stat_o.started   = started_q;
  assign stat_o.sample_ok = sok_q;
  assign stat_o.direct    = !valid_q || (dt_q == '0);

  // Control state: configuration, flags, the time base and the roll, pitch and yaw estimates.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q <= 1'b0;
      valid_q   <= 1'b0;
      last_q    <= '0;
      roll_q    <= '0;
      pitch_q   <= '0;
      yaw_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        started_q <= cfg_data_i;
        if (cfg_data_i) begin
          last_q  <= '0;
          valid_q <= 1'b0;
        end
      end
      case (cmd_i.op)
        OP_FAIL:   valid_q <= 1'b0;
        OP_SQ_A:   last_q <= now_q;
        OP_FINISH: if (cmd_i.ok) valid_q <= 1'b1;
        OP_DIRECT: begin
          roll_q  <= sat_angle((ACC_W+1)'(acc_roll_q));
          pitch_q <= sat_angle((ACC_W+1)'(acc_pitch_q));
        end
        OP_DIV_DONE: begin
          case (cmd_i.tgt)
            T_ROLL:  roll_q <= sat_angle(quot);
            T_PITCH: pitch_q <= sat_angle(quot);
            T_YAW:   yaw_q <= quot[15:0];
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end

  // Working registers of the datapath.
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        ax_q  <= accel_x_i;
        ay_q  <= accel_y_i;
        az_q  <= accel_z_i;
        gx_q  <= gyro_x_i;
        gy_q  <= gyro_y_i;
        gz_q  <= gyro_z_i;
        now_q <= now_ms_i;
        sok_q <= sample_ok_i;
      end
      OP_SQ_A: begin
        if ((last_q != '0) && (now_q > last_q)) begin
          dt_q <= (diff > 32'd65535) ? 16'hFFFF : diff[15:0];
        end else begin
          dt_q <= '0;
        end
        sq_p_q <= 32'(ay_q * ay_q);
      end
      OP_SQ_B: begin
        sq_v_q   <= {SQ_W'(sq_p_q + az_sq)} << 16;
        sq_res_q <= '0;
        sq_bit_q <= SQ_W'(1) << (SQ_W - 2);
      end
      OP_SQRT: begin
        if (sq_v_q >= sq_trial) begin
          sq_v_q   <= sq_v_q - sq_trial;
          sq_res_q <= (sq_res_q >> 1) + sq_bit_q;
        end else begin
          sq_res_q <= sq_res_q >> 1;
        end
        sq_bit_q <= sq_bit_q >> 2;
      end
      OP_COR_INIT: begin
        czero_q <= (x0 == '0) && (y0 == '0);
        if (x0 < 0) begin
          cz_q <= (y0 >= 0) ? Z_HALF_TURN : -Z_HALF_TURN;
          cx_q <= COR_W'(-x0) <<< 16;
          cy_q <= COR_W'(-y0) <<< 16;
        end else begin
          cz_q <= '0;
          cx_q <= COR_W'(x0) <<< 16;
          cy_q <= COR_W'(y0) <<< 16;
        end
      end
      OP_COR_STEP: begin
        if (cy_q > 0) begin
          cx_q <= cx_q + ys;
          cy_q <= cy_q - xs;
          cz_q <= cz_q + atan_s;
        end else begin
          cx_q <= cx_q - ys;
          cy_q <= cy_q + xs;
          cz_q <= cz_q - atan_s;
        end
      end
      OP_DIV_INIT: begin
        dneg_q <= div_n < 0;
        dvd_q  <= div_mag + ACC_W'(div_d >> 1);
        dvs_q  <= div_d;
      end
      OP_DIV_STEP: begin
        // Low and high halves of the reciprocal product, then the estimate and
        // its single correction.
        case (cmd_i.iter[1:0])
          PH_LO:   prod_q <= 64'(p_lo);
          PH_HI:   prod_q <= prod_q + (64'(p_hi) << 19);
          PH_EST:  quo_q <= q_est;
          PH_FIX:  if (rem_chk >= ACC_W'(dvs_q)) quo_q <= quo_q + 24'd1;
          default: ;
        endcase
      end
      OP_DIV_DONE: begin
        if (cmd_i.tgt == T_ACC_ROLL) acc_roll_q <= quot[15:0];
        if (cmd_i.tgt == T_ACC_PITCH) acc_pitch_q <= quot[15:0];
      end
      OP_BL_MUL:   acc_q <= ACC_W'(p_gdt);
      OP_BL_ADD:   acc_q <= acc_q + ACC_W'(p_old);
      OP_BL_SCALE: acc_q <= p_scale[ACC_W-1:0];
      OP_BL_ACC:   acc_q <= acc_q + ACC_W'(p_acc);
      OP_YAW_MUL:  acc_q <= ACC_W'(p_yaw);
      OP_FINISH: begin
        o_ok_q    <= cmd_i.ok;
        o_valid_q <= cmd_i.ok ? 1'b1 : valid_q;
        o_roll_q  <= roll_q;
        o_pitch_q <= pitch_q;
        o_yaw_q   <= yaw_q;
      end
      default: ;
    endcase
  end

  assign ok_o             = o_ok_q;
  assign roll_angle_o     = o_roll_q;
  assign pitch_angle_o    = o_pitch_q;
  assign yaw_rate_o       = o_yaw_q;
  assign attitude_valid_o = o_valid_q;

endmodule

// File: hdl/imuatt_ctrl.sv
module imuatt_ctrl #(
  parameter int unsigned CORDIC_ITERATIONS = imuatt_pkg::CORDIC_ITER_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  imuatt_pkg::stat_t stat_i,
  output imuatt_pkg::cmd_t  cmd_o
);
  import imuatt_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE,
    S_CHECK,
    S_SQ_B,
    S_SQRT,
    S_COR_INIT,
    S_COR_RUN,
    S_DIV_INIT,
    S_DIV_RUN,
    S_DIV_DONE,
    S_DIRECT,
    S_BL_MUL,
    S_BL_ADD,
    S_BL_SCALE,
    S_BL_ACC,
    S_YAW,
    S_FIN_OK,
    S_FIN_NOK
  } state_e;

  state_e            state_q;
  logic [ITER_W-1:0] cnt_q;
  tgt_e              tgt_q;
  logic              axis_q;
  logic              out_valid_q;
  logic              fin_go;

  assign fin_go      = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o.op   = OP_NONE;
    cmd_o.tgt  = tgt_q;
    cmd_o.axis = axis_q;
    cmd_o.ok   = (state_q == S_FIN_OK);
    cmd_o.iter = cnt_q;
    case (state_q)
      S_IDLE: if (in_valid_i) cmd_o.op = OP_LOAD;
      S_CHECK: begin
        if (!stat_i.started) begin
          cmd_o.op = OP_NONE;
        end else if (!stat_i.sample_ok) begin
          cmd_o.op = OP_FAIL;
        end else begin
          cmd_o.op = OP_SQ_A;
        end
      end
      S_SQ_B:     cmd_o.op = OP_SQ_B;
      S_SQRT:     cmd_o.op = OP_SQRT;
      S_COR_INIT: cmd_o.op = OP_COR_INIT;
      S_COR_RUN:  cmd_o.op = OP_COR_STEP;
      S_DIV_INIT: cmd_o.op = OP_DIV_INIT;
      S_DIV_RUN:  cmd_o.op = OP_DIV_STEP;
      S_DIV_DONE: cmd_o.op = OP_DIV_DONE;
      S_DIRECT:   cmd_o.op = OP_DIRECT;
      S_BL_MUL:   cmd_o.op = OP_BL_MUL;
      S_BL_ADD:   cmd_o.op = OP_BL_ADD;
      S_BL_SCALE: cmd_o.op = OP_BL_SCALE;
      S_BL_ACC:   cmd_o.op = OP_BL_ACC;
      S_YAW:      cmd_o.op = OP_YAW_MUL;
      S_FIN_OK, S_FIN_NOK: if (fin_go) cmd_o.op = OP_FINISH;
      default:    cmd_o.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      tgt_q       <= T_ACC_ROLL;
      axis_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: if (in_valid_i) state_q <= S_CHECK;
        S_CHECK: begin
          if (!stat_i.started || !stat_i.sample_ok) begin
            state_q <= S_FIN_NOK;
          end else begin
            state_q <= S_SQ_B;
          end
        end
        S_SQ_B: begin
          cnt_q   <= '0;
          state_q <= S_SQRT;
        end
        S_SQRT: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == ITER_W'(SQRT_STEPS - 1)) begin
            axis_q  <= 1'b0;
            state_q <= S_COR_INIT;
          end
        end
        S_COR_INIT: begin
          cnt_q   <= '0;
          state_q <= S_COR_RUN;
        end
        S_COR_RUN: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == ITER_W'(CORDIC_ITERATIONS - 1)) begin
            tgt_q   <= axis_q ? T_ACC_PITCH : T_ACC_ROLL;
            state_q <= S_DIV_INIT;
          end
        end
        S_DIV_INIT: begin
          cnt_q   <= '0;
          state_q <= S_DIV_RUN;
        end
        S_DIV_RUN: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == ITER_W'(DIV_STEPS - 1)) state_q <= S_DIV_DONE;
        end
        S_DIV_DONE: begin
          case (tgt_q)
            T_ACC_ROLL: begin
              axis_q  <= 1'b1;
              state_q <= S_COR_INIT;
            end
            T_ACC_PITCH: begin
              axis_q  <= 1'b0;
              state_q <= stat_i.direct ? S_DIRECT : S_BL_MUL;
            end
            T_ROLL: begin
              axis_q  <= 1'b1;
              state_q <= S_BL_MUL;
            end
            T_PITCH: state_q <= S_YAW;
            default: state_q <= S_FIN_OK;
          endcase
        end
        S_DIRECT:   state_q <= S_YAW;
        S_BL_MUL:   state_q <= S_BL_ADD;
        S_BL_ADD:   state_q <= S_BL_SCALE;
        S_BL_SCALE: state_q <= S_BL_ACC;
        S_BL_ACC: begin
          tgt_q   <= axis_q ? T_PITCH : T_ROLL;
          state_q <= S_DIV_INIT;
        end
        S_YAW: begin
          tgt_q   <= T_YAW;
          state_q <= S_DIV_INIT;
        end
        S_FIN_OK, S_FIN_NOK: begin
          if (fin_go) begin
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Work starts only on an accepted beat.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && !in_valid_i) |=> state_q == S_IDLE)
    else $error("sequencer left idle without an input beat");

  // A finishing item always lands in the output register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_FIN_OK || state_q == S_FIN_NOK) && fin_go) |=> out_valid_q)
    else $error("finished result not presented");

  // Iteration counters stay inside their loops.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SQRT |-> cnt_q < ITER_W'(SQRT_STEPS))
    else $error("square root ran too many steps");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DIV_RUN |-> cnt_q < ITER_W'(DIV_STEPS))
    else $error("divider ran too many steps");

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps

module tb;
  import imuatt_pkg::*;

  localparam int unsigned TURN     = 16;         // CORDIC iterations of the instance
  localparam longint      RUN_CAP  = 3000000;    // cycle limit for the whole run
  localparam int          TAIL_CYC = 400;        // quiet cycles after the last result

  typedef struct {
    logic signed [15:0] ax, ay, az, gx, gy, gz;
    logic               sok;
    logic [31:0]        now;
  } imu_beat_t;

  typedef struct {
    logic               ok;
    logic signed [15:0] roll, pitch, yaw;
    logic               att_valid;
  } attitude_t;

  // Arctangent of 2^-i in micro-degrees.
  localparam longint ATAN_TAB [24] = '{
    45000000, 26565051, 14036243, 7125016, 3576334, 1789911, 895174, 447614,
    223811, 111906, 55953, 27976, 13988, 6994, 3497, 1749,
    874, 437, 219, 109, 55, 27, 14, 7};

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  imuatt_in_if  smp ();
  imuatt_out_if res ();
  imuatt_cfg_if cfg ();

  imu_complementary_attitude #(.CORDIC_ITERATIONS(TURN)) i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .sample_i(smp),
    .result_o(res),
    .cfg_i   (cfg)
  );

  always #6 clk_i = ~clk_i;

  // Shadow copy of the estimator state, advanced on every accepted beat.
  logic               est_started, est_valid;
  logic signed [15:0] est_roll, est_pitch, est_yaw;
  logic [31:0]        est_last_ms;

  imu_beat_t  pending_q[$];     // beats waiting for the driver
  attitude_t  attitude_q[$];    // predicted results, oldest first
  imu_beat_t  cur_beat;
  int         fail_cnt;
  longint     cyc_cnt;

  // Handshake variables between the stimulus sequence and the clocked processes.
  logic       cfg_pend, cfg_pend_val;
  int         hold_req;

  // Division rounded half away from zero.
  function automatic longint div_half_away(longint n, longint d);
    if (n >= 0) return (n + d / 2) / d;
    return -((-n + d / 2) / d);
  endfunction

  function automatic longint clamp_angle(longint v);
    if (v > 18000) return 18000;
    if (v < -18000) return -18000;
    return v;
  endfunction

  function automatic longint unsigned int_root(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // Vectoring CORDIC atan2 in hundredths of a degree.
  function automatic longint atan2_cdeg(longint y, longint x);
    longint z, xs, ys;
    if (x == 0 && y == 0) return 0;
    z = 0;
    if (x < 0) begin
      z = (y >= 0) ? 180000000 : -180000000;
      x = -x;
      y = -y;
    end
    x = x * 65536;
    y = y * 65536;
    for (int i = 0; i < TURN && i < 24; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x += ys; y -= xs; z += ATAN_TAB[i];
      end else begin
        x -= ys; y += xs; z -= ATAN_TAB[i];
      end
    end
    return div_half_away(z, 10000);
  endfunction

  function automatic longint blend_angle(longint prev, longint rate, longint dt, longint acc);
    return clamp_angle(div_half_away(98 * (prev * 1310 + rate * dt) + 2620 * acc, 131000));
  endfunction

  // Advances the shadow state by one beat and returns the attitude it should produce.
  function automatic attitude_t update_attitude(imu_beat_t b);
    attitude_t      a;
    longint         ax, ay, az, dt, acc_r, acc_p;
    longint unsigned sq;
    a.ok = 1'b0;
    if (est_started) begin
      if (!b.sok) begin
        est_valid = 1'b0;
      end else begin
        ax = b.ax; ay = b.ay; az = b.az;
        dt = 0;
        if (est_last_ms != 0 && b.now > est_last_ms)
          dt = (b.now - est_last_ms > 65535) ? 65535 : longint'(b.now - est_last_ms);
        est_last_ms = b.now;
        sq = longint'(ay * ay + az * az) * 65536;
        acc_r = atan2_cdeg(ay * 256, az * 256);
        acc_p = atan2_cdeg(-ax * 256, longint'(int_root(sq)));
        if (!est_valid || dt == 0) begin
          est_roll  = 16'(clamp_angle(acc_r));
          est_pitch = 16'(clamp_angle(acc_p));
        end else begin
          est_roll  = 16'(blend_angle(est_roll, longint'(b.gx), dt, acc_r));
          est_pitch = 16'(blend_angle(est_pitch, longint'(b.gy), dt, acc_p));
        end
        est_yaw   = 16'(div_half_away(longint'(b.gz) * 100, 131));
        est_valid = 1'b1;
        a.ok      = 1'b1;
      end
    end
    a.roll      = est_roll;
    a.pitch     = est_pitch;
    a.yaw       = est_yaw;
    a.att_valid = est_valid;
    return a;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("[%0t] %s: got %0d, expected %0d", $time, what, got, want);
    fail_cnt++;
  endtask

  // Sample driver: bursts of random length separated by random gaps.
  int burst_left, gap_left;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      smp.valid  <= 1'b0;
      burst_left <= 0;
      gap_left   <= 0;
    end else begin
      if (smp.valid && smp.ready) attitude_q.push_back(update_attitude(cur_beat));
      if (!smp.valid || smp.ready) begin
        if (gap_left > 0) begin
          gap_left  <= gap_left - 1;
          smp.valid <= 1'b0;
        end else if (pending_q.size() > 0) begin
          cur_beat       = pending_q.pop_front();
          smp.valid     <= 1'b1;
          smp.accel_x   <= cur_beat.ax;
          smp.accel_y   <= cur_beat.ay;
          smp.accel_z   <= cur_beat.az;
          smp.gyro_x    <= cur_beat.gx;
          smp.gyro_y    <= cur_beat.gy;
          smp.gyro_z    <= cur_beat.gz;
          smp.sample_ok <= cur_beat.sok;
          smp.now_ms    <= cur_beat.now;
          if (burst_left <= 1) begin
            // A third of the bursts run back to back with no gap at all.
            burst_left <= $urandom_range(1, 40);
            gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 400);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          smp.valid <= 1'b0;
        end
      end
    end
  end

  // Configuration driver. A register write of 1 also restarts the shadow estimator.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg.valid <= 1'b0;
      cfg.data  <= 1'b0;
    end else if (cfg.valid && cfg.ready) begin
      est_started = cfg.data;
      if (cfg.data) begin
        est_last_ms = '0;
        est_valid   = 1'b0;
      end
      cfg.valid <= 1'b0;
      cfg_pend   = 1'b0;
    end else if (cfg_pend && !cfg.valid) begin
      cfg.valid <= 1'b1;
      cfg.data  <= cfg_pend_val;
    end
  end

  // Receiver stall pattern: the mode changes at random intervals, and a
  // requested hold-off keeps ready low long enough to back the block up.
  int stall_mode, mode_left, hold_cnt;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res.ready  <= 1'b0;
      stall_mode <= 0;
      mode_left  <= 0;
      hold_cnt   <= 0;
    end else begin
      if (hold_req > 0) begin
        hold_cnt <= hold_req;
        hold_req  = 0;
      end else if (hold_cnt > 0) begin
        hold_cnt <= hold_cnt - 1;
      end
      if (mode_left == 0) begin
        stall_mode <= $urandom_range(0, 3);
        mode_left  <= $urandom_range(50, 800);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (stall_mode)
        0:       res.ready <= (hold_cnt == 0);
        1:       res.ready <= (hold_cnt == 0) && ($urandom_range(0, 1) == 1);
        2:       res.ready <= (hold_cnt == 0) && ($urandom_range(0, 7) == 0);
        default: res.ready <= (hold_cnt == 0) && ($urandom_range(0, 99) >= 3);
      endcase
    end
  end

  // Result monitor: every result beat is checked against the oldest prediction.
  attitude_t want;
  always @(posedge clk_i) begin
    if (rst_ni && res.valid && res.ready) begin
      if (attitude_q.size() == 0) begin
        $display("[%0t] result beat with nothing predicted", $time);
        fail_cnt++;
      end else begin
        want = attitude_q.pop_front();
        if (res.ok !== want.ok) report_mismatch("ok", res.ok, want.ok);
        if (res.roll_angle !== want.roll) report_mismatch("roll", res.roll_angle, want.roll);
        if (res.pitch_angle !== want.pitch)
          report_mismatch("pitch", res.pitch_angle, want.pitch);
        if (res.yaw_rate !== want.yaw) report_mismatch("yaw", res.yaw_rate, want.yaw);
        if (res.attitude_valid !== want.att_valid)
          report_mismatch("attitude_valid", res.attitude_valid, want.att_valid);
      end
    end
  end

  always @(posedge clk_i) begin
    cyc_cnt++;
    if (cyc_cnt > RUN_CAP) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Running millisecond clock for the random stream.
  logic [31:0] stamp_ms;

  function automatic imu_beat_t make_beat(logic signed [15:0] ax, logic signed [15:0] ay,
                                          logic signed [15:0] az, logic signed [15:0] gx,
                                          logic signed [15:0] gy, logic signed [15:0] gz,
                                          logic sok, logic [31:0] now);
    imu_beat_t b;
    b.ax = ax; b.ay = ay; b.az = az;
    b.gx = gx; b.gy = gy; b.gz = gz;
    b.sok = sok; b.now = now;
    return b;
  endfunction

  // Mostly a sensor near rest with small rotation rates and steady time steps;
  // the rest is full-range noise, failed reads, stalled or rewound clocks and long gaps.
  function automatic imu_beat_t random_beat();
    imu_beat_t b;
    int        r;
    if ($urandom_range(0, 9) < 7) begin
      b.ax = 16'($signed($urandom_range(0, 8000)) - 4000);
      b.ay = 16'($signed($urandom_range(0, 8000)) - 4000);
      b.az = ($urandom_range(0, 5) == 0) ? -16'sd16384 : 16'sd16384;
      b.az = b.az + 16'($signed($urandom_range(0, 2000)) - 1000);
    end else begin
      b.ax = 16'($urandom);
      b.ay = 16'($urandom);
      b.az = 16'($urandom);
    end
    if ($urandom_range(0, 4) == 0) begin
      b.gx = 16'($urandom); b.gy = 16'($urandom); b.gz = 16'($urandom);
    end else begin
      b.gx = 16'($signed($urandom_range(0, 4000)) - 2000);
      b.gy = 16'($signed($urandom_range(0, 4000)) - 2000);
      b.gz = 16'($signed($urandom_range(0, 4000)) - 2000);
    end
    b.sok = ($urandom_range(0, 19) != 0);
    r = $urandom_range(0, 99);
    if (r < 3)       stamp_ms = stamp_ms;
    else if (r < 5)  stamp_ms = stamp_ms - $urandom_range(1, 5000);
    else if (r < 7)  stamp_ms = stamp_ms + $urandom_range(65536, 300000);
    else if (r < 8)  stamp_ms = $urandom;
    else if (r < 9)  stamp_ms = 0;
    else             stamp_ms = stamp_ms + $urandom_range(1, 30);
    b.now = stamp_ms;
    return b;
  endfunction

  task automatic wait_drained();
    while (pending_q.size() > 0 || smp.valid || attitude_q.size() > 0) @(negedge clk_i);
  endtask

  task automatic write_started(logic val);
    wait_drained();
    // Extra margin so no beat is still in flight when the register changes.
    repeat (TAIL_CYC) @(negedge clk_i);
    cfg_pend_val = val;
    cfg_pend     = 1'b1;
    while (cfg_pend) @(negedge clk_i);
  endtask

  initial begin
    smp.valid = 1'b0; smp.accel_x = '0; smp.accel_y = '0; smp.accel_z = '0;
    smp.gyro_x = '0; smp.gyro_y = '0; smp.gyro_z = '0; smp.sample_ok = 1'b0;
    smp.now_ms = '0; res.ready = 1'b0; cfg.valid = 1'b0; cfg.data = 1'b0;
    est_started = 1'b0; est_valid = 1'b0; est_roll = '0; est_pitch = '0; est_yaw = '0;
    est_last_ms = '0; fail_cnt = 0; cyc_cnt = 0; cfg_pend = 1'b0; cfg_pend_val = 1'b0;
    hold_req = 0; stamp_ms = 32'd1000;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Before the sensor is started, samples are ignored.
    pending_q.push_back(make_beat(16'sd100, 16'sd200, 16'sd16384, 16'sd50, 16'sd60, 16'sd131,
                                  1'b1, 32'd10));
    pending_q.push_back(make_beat(-16'sd1, 16'sd1, -16'sd1, 16'sd1, -16'sd1, 16'sd1,
                                  1'b0, 32'd20));
    write_started(1'b1);

    // Directed: first sample loads, then filtered steps, field extremes and corner vectors.
    pending_q.push_back(make_beat(16'sd0, 16'sd0, 16'sd16384, 16'sd0, 16'sd0, 16'sd0,
                                  1'b1, 32'd100));
    pending_q.push_back(make_beat(16'sd2000, -16'sd3000, 16'sd15000, 16'sd1310, -16'sd1310,
                                  16'sd131, 1'b1, 32'd110));
    pending_q.push_back(make_beat(-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768,
                                  -16'sd32768, -16'sd32768, 1'b1, 32'd120));
    pending_q.push_back(make_beat(16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767,
                                  16'sd32767, 16'sd32767, 1'b1, 32'd130));
    // Zero vector in both atan2 calls.
    pending_q.push_back(make_beat(16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0,
                                  1'b1, 32'd140));
    // Negative x with zero y: the accelerometer roll lands exactly on +180 degrees.
    pending_q.push_back(make_beat(16'sd0, 16'sd0, -16'sd16384, 16'sd500, 16'sd500,
                                  -16'sd500, 1'b1, 32'd150));
    // Failed read clears valid; the next good one reloads.
    pending_q.push_back(make_beat(16'sd5, 16'sd5, 16'sd5, 16'sd5, 16'sd5, 16'sd5,
                                  1'b0, 32'd160));
    pending_q.push_back(make_beat(16'sd4000, 16'sd4000, 16'sd12000, 16'sd100, 16'sd100,
                                  16'sd100, 1'b1, 32'd170));
    // Same time stamp, then a rewound clock: both reload the accelerometer angles.
    pending_q.push_back(make_beat(16'sd4000, 16'sd4000, 16'sd12000, 16'sd9000, 16'sd9000,
                                  16'sd65, 1'b1, 32'd170));
    pending_q.push_back(make_beat(-16'sd4000, 16'sd4000, 16'sd12000, 16'sd9000, 16'sd9000,
                                  -16'sd65, 1'b1, 32'd50));
    // Long gap clamped to 65535 ms with large rates, driving the angles into saturation.
    pending_q.push_back(make_beat(16'sd0, 16'sd0, 16'sd16384, 16'sd32767, -16'sd32768,
                                  16'sd32767, 1'b1, 32'd200000));
    pending_q.push_back(make_beat(16'sd0, 16'sd0, 16'sd16384, 16'sd32767, -16'sd32768,
                                  16'sd32767, 1'b1, 32'hFFFF_FFFF));
    // Time of zero after a valid estimate, then a small step.
    pending_q.push_back(make_beat(16'sd100, -16'sd100, 16'sd16000, 16'sd10, 16'sd10,
                                  16'sd10, 1'b1, 32'd0));
    pending_q.push_back(make_beat(16'sd100, -16'sd100, 16'sd16000, 16'sd10, 16'sd10,
                                  16'sd10, 1'b1, 32'd1));
    pending_q.push_back(make_beat(16'sd100, -16'sd100, 16'sd16000, 16'sd10, 16'sd10,
                                  16'sd10, 1'b1, 32'd2));

    // Random stream, part one, with a long receiver hold-off while the sender keeps going.
    for (int n = 0; n < 900; n++) begin
      pending_q.push_back(random_beat());
      if (n == 300) hold_req = 3000;
    end
    // The sender waits here until every predicted result is back.
    wait_drained();
    for (int n = 0; n < 100; n++) pending_q.push_back(random_beat());

    // Stop the sensor: a few ignored samples, then restart it.
    write_started(1'b0);
    for (int n = 0; n < 30; n++) pending_q.push_back(random_beat());
    write_started(1'b1);
    for (int n = 0; n < 900; n++) begin
      pending_q.push_back(random_beat());
      if (n == 500) hold_req = 2500;
    end

    wait_drained();
    repeat (TAIL_CYC) @(posedge clk_i);
    if (fail_cnt == 0 && attitude_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// File: filelist.f
hdl/imuatt_pkg.sv
hdl/imuatt_in_if.sv
hdl/imuatt_out_if.sv
hdl/imuatt_cfg_if.sv
hdl/imuatt_dp.sv
hdl/imuatt_ctrl.sv
hdl/imu_complementary_attitude.sv
dv/tb.sv
